@@ design/weighted_round_robin_arbiter_unit_assert.svh @@
// Assertion macros used by the checker file wrra_checker.sv.
`ifndef WEIGHTED_ROUND_ROBIN_ARBITER_UNIT_ASSERT_SVH
`define WEIGHTED_ROUND_ROBIN_ARBITER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define WRRA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wrra: assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define WRRA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wrra: assertion failed");

`endif

@@ design/wrra_pkg.sv @@
package wrra_pkg;

    localparam int NUM_QUEUES_DEF = 4;
    localparam int MAX_QUEUES     = 4;
    localparam int QUANTUM_W      = 8;
    localparam int QIDX_W         = 2;
    localparam int CFG_IDX_W      = 2;

    typedef logic [QUANTUM_W-1:0] quantum_t;
    typedef logic [QIDX_W-1:0]    qidx_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam quantum_t QUANTUM_RESET = quantum_t'(1);

    localparam cfg_idx_t REG_QUANTUM_Q0 = cfg_idx_t'(0);
    localparam cfg_idx_t REG_QUANTUM_Q1 = cfg_idx_t'(1);
    localparam cfg_idx_t REG_QUANTUM_Q2 = cfg_idx_t'(2);
    localparam cfg_idx_t REG_QUANTUM_Q3 = cfg_idx_t'(3);

    typedef struct packed {
        logic  grant_valid;
        qidx_t grant_queue;
    } grant_t;

    typedef struct packed {
        logic  loaded;
        logic  last_valid;
        qidx_t last_granted;
    } arb_state_t;

endpackage

@@ design/wrra_if.sv @@
interface wrra_req_if;
    logic       valid;
    logic       ready;
    logic [3:0] queue_nonempty;

    modport source (output valid, output queue_nonempty, input ready);
    modport sink (input valid, input queue_nonempty, output ready);
endinterface

interface wrra_grant_if;
    logic       valid;
    logic       ready;
    logic       grant_valid;
    logic [1:0] grant_queue;

    modport source (output valid, output grant_valid, output grant_queue, input ready);
    modport sink (input valid, input grant_valid, input grant_queue, output ready);
endinterface

@@ design/wrra_pick.sv @@
module wrra_pick #(
    parameter int NUM_QUEUES = wrra_pkg::NUM_QUEUES_DEF
) (
    input  logic [NUM_QUEUES-1:0] mask,
    input  wrra_pkg::quantum_t    quantum [NUM_QUEUES],
    input  wrra_pkg::quantum_t    left [NUM_QUEUES],
    input  wrra_pkg::arb_state_t  st,
    output wrra_pkg::grant_t      grant,
    output wrra_pkg::quantum_t    left_next [NUM_QUEUES],
    output wrra_pkg::arb_state_t  st_next
);
    import wrra_pkg::*;

    localparam int POS_W = QIDX_W + 1;

    // First set bit of vec in rotating order from start; MSB is the found flag.
    function automatic logic [POS_W-1:0] rr_first(input logic [NUM_QUEUES-1:0] vec,
                                                  input qidx_t start);
        logic [POS_W-1:0] pos;
        logic             found;
        qidx_t            idx;
        found = 1'b0;
        idx   = '0;
        for (int i = 0; i < NUM_QUEUES; i++)
        begin
            pos = {1'b0, start} + POS_W'(i);
            if (pos >= POS_W'(NUM_QUEUES))
            begin
                pos = pos - POS_W'(NUM_QUEUES);
            end
            for (int q = 0; q < NUM_QUEUES; q++)
            begin
                if (!found && vec[q] && (pos == POS_W'(q)))
                begin
                    found = 1'b1;
                    idx   = QIDX_W'(q);
                end
            end
        end
        return {found, idx};
    endfunction

    quantum_t              cur [NUM_QUEUES];
    quantum_t              base [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] elig;
    logic                  last_hit;
    qidx_t                 start;
    logic [POS_W-1:0]      search_res;
    logic [POS_W-1:0]      reload_res;
    logic                  reload;
    logic                  any_req;
    qidx_t                 gq;

    always_comb
    begin
        last_hit = 1'b0;
        for (int q = 0; q < NUM_QUEUES; q++)
        begin
            // counters are loaded from the quantum registers on the first word
            cur[q]  = st.loaded ? left[q] : quantum[q];
            elig[q] = mask[q] && (cur[q] != '0);
            if (st.last_valid && (st.last_granted == QIDX_W'(q)) && elig[q])
            begin
                last_hit = 1'b1;
            end
        end

        if (!st.last_valid || (st.last_granted == QIDX_W'(NUM_QUEUES - 1)))
        begin
            start = '0;
        end
        else
        begin
            start = st.last_granted + qidx_t'(1);
        end

        search_res = rr_first(elig, start);
        reload_res = rr_first(mask, start);
        any_req    = |mask;
        reload     = !last_hit && !search_res[POS_W-1] && any_req;

        if (last_hit)
        begin
            gq = st.last_granted;
        end
        else if (search_res[POS_W-1])
        begin
            gq = search_res[QIDX_W-1:0];
        end
        else if (any_req)
        begin
            gq = reload_res[QIDX_W-1:0];
        end
        else
        begin
            gq = '0;
        end

        for (int q = 0; q < NUM_QUEUES; q++)
        begin
            base[q] = reload ? quantum[q] : cur[q];
            if (any_req && (gq == QIDX_W'(q)) && (base[q] != '0))
            begin
                left_next[q] = base[q] - quantum_t'(1);
            end
            else
            begin
                left_next[q] = base[q];
            end
        end

        grant.grant_valid = any_req;
        grant.grant_queue = gq;

        st_next.loaded       = 1'b1;
        st_next.last_valid   = st.last_valid || any_req;
        st_next.last_granted = any_req ? gq : st.last_granted;
    end

endmodule

@@ design/weighted_round_robin_arbiter_unit.sv @@
// Path: an accepted request word is held in the input register, then its grant
// word is written to the grant register after arbitration.
// Throughput: one word per cycle; the grant register and the counter update share
// the same arbitration logic. A stalled grant holds both stages.
// Reset: quantum registers go to 1, counters to 0, no grant history, pipeline empty.
module weighted_round_robin_arbiter_unit #(
    parameter int NUM_QUEUES = wrra_pkg::NUM_QUEUES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    wrra_req_if.sink            req,
    wrra_grant_if.source        grant,
    input  logic                cfg_we,
    input  wrra_pkg::cfg_idx_t  cfg_index,
    input  wrra_pkg::quantum_t  cfg_data
);
    import wrra_pkg::*;

    quantum_t              quantum_reg [MAX_QUEUES];
    quantum_t              left_reg [NUM_QUEUES];
    quantum_t              left_next [NUM_QUEUES];
    quantum_t              quantum_use [NUM_QUEUES];
    arb_state_t            st_reg;
    arb_state_t            st_next;
    grant_t                grant_reg;
    grant_t                grant_next;
    logic                  in_valid_reg;
    logic [NUM_QUEUES-1:0] mask_reg;
    logic                  out_valid_reg;
    logic                  advance;

    assign advance   = !out_valid_reg || grant.ready;
    assign req.ready = !in_valid_reg || advance;

    assign grant.valid       = out_valid_reg;
    assign grant.grant_valid = grant_reg.grant_valid;
    assign grant.grant_queue = grant_reg.grant_queue;

    always_comb
    begin
        for (int q = 0; q < NUM_QUEUES; q++)
        begin
            quantum_use[q] = quantum_reg[q];
        end
    end

    wrra_pick #(
        .NUM_QUEUES (NUM_QUEUES)
    ) u_pick (
        .mask      (mask_reg),
        .quantum   (quantum_use),
        .left      (left_reg),
        .st        (st_reg),
        .grant     (grant_next),
        .left_next (left_next),
        .st_next   (st_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int q = 0; q < MAX_QUEUES; q++)
            begin
                quantum_reg[q] <= QUANTUM_RESET;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_QUANTUM_Q0: quantum_reg[0] <= cfg_data;
                REG_QUANTUM_Q1: quantum_reg[1] <= cfg_data;
                REG_QUANTUM_Q2: quantum_reg[2] <= cfg_data;
                REG_QUANTUM_Q3: quantum_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            mask_reg <= req.queue_nonempty[NUM_QUEUES-1:0];
        end
    end

    // grant stage and arbitration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
            for (int q = 0; q < NUM_QUEUES; q++)
            begin
                left_reg[q] <= '0;
            end
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                st_reg <= st_next;
                for (int q = 0; q < NUM_QUEUES; q++)
                begin
                    left_reg[q] <= left_next[q];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            grant_reg <= grant_next;
        end
    end

endmodule

@@ design/wrra_checker.sv @@
`include "weighted_round_robin_arbiter_unit_assert.svh"

module wrra_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       grant_hs_valid,
    input logic       grant_hs_ready,
    input logic       grant_valid,
    input logic [1:0] grant_queue
);

    // a stalled grant word holds
    `WRRA_ASSERT_NEXT(a_grant_hold, grant_hs_valid && !grant_hs_ready, grant_hs_valid && $stable(grant_valid) && $stable(grant_queue))

    // a fresh grant word follows a request word taken earlier into the input register
    `WRRA_ASSERT_SAME(a_grant_from_req, $rose(grant_hs_valid), $past(req_valid && req_ready, 2))

    // requests are only held off while a grant word is stalled
    `WRRA_ASSERT_SAME(a_backpressure, !req_ready, grant_hs_valid && !grant_hs_ready)

    // no grant means queue field reads zero
    `WRRA_ASSERT_SAME(a_nogrant_zero, grant_hs_valid && !grant_valid, grant_queue == 2'd0)

endmodule

bind weighted_round_robin_arbiter_unit wrra_checker u_wrra_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .grant_hs_valid (grant.valid),
    .grant_hs_ready (grant.ready),
    .grant_valid    (grant.grant_valid),
    .grant_queue    (grant.grant_queue)
);
